/* rtl/ur3_pkg.sv */
// Shared types and constants for the ultrasonic ranger with median-of-three filter.
// No dependencies; used by ur3_timing, ur3_filter and ultrasonic_ranger_median3.
package ur3_pkg;

    localparam int TIME_WIDTH_DEF = 16;
    localparam int DIST_WIDTH_DEF = 14;

    localparam int CFG_WIDTH     = 16;
    localparam int CFG_IDX_WIDTH = 2;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_TRIGGER_PERIOD = 2'd0,
        REG_ECHO_TIMEOUT   = 2'd1,
        REG_MAX_ECHO_TICKS = 2'd2
    } t_cfg_reg;

    localparam logic [CFG_WIDTH-1:0] TRIGGER_PERIOD_RST = 16'd30000;
    localparam logic [CFG_WIDTH-1:0] ECHO_TIMEOUT_RST   = 16'd30000;
    localparam logic [CFG_WIDTH-1:0] MAX_ECHO_TICKS_RST = 16'd23323;

    // trigger pulse: phase 0 idle, 1..LOW_TICKS low, then HIGH_TICKS high
    localparam int PHASE_WIDTH = 4;
    localparam int LOW_TICKS   = 2;
    localparam int HIGH_TICKS  = 10;
    localparam int PHASE_LAST  = LOW_TICKS + HIGH_TICKS;

    // ticks to sixteenths of a cm: (dur * 281) >> 10
    localparam int SCALE_MUL   = 281;
    localparam int SCALE_BITS  = 9;
    localparam int SCALE_SHIFT = 10;

    localparam int DIST_RESET = 15984;   // 999 cm

    typedef struct packed {
        logic [CFG_WIDTH-1:0] trigger_period;
        logic [CFG_WIDTH-1:0] echo_timeout;
        logic [CFG_WIDTH-1:0] max_echo_ticks;
    } t_cfg;

    typedef struct packed {
        logic drive;   // pin driven this tick
        logic level;   // driven level
        logic fall;    // falling echo edge while listening
    } t_tmg_status;

endpackage

/* rtl/ultrasonic_ranger_median3.sv */
// Ultrasonic echo ranger top level: configuration registers, timing, filter, result register.
// Depends on ur3_pkg, ur3_timing and ur3_filter.
//
// One input item is one microsecond tick carrying the sampled echo pin level; every accepted
// tick yields exactly one result (pin drive enable, driven level, median distance in
// sixteenths of a cm, sample-accepted flag). The block takes one tick per clock cycle while
// o_stall is low; the result is registered in the cycle after the tick is accepted; the whole
// state update, including the 281/1024 scaling multiply and the median-of-three compare, is
// combinational. The result register lets a new tick be accepted while the previous result
// waits; o_stall rises only when that register is full and downstream stalls. Configuration
// writes are always ready and should be made while no tick is in flight.
module ultrasonic_ranger_median3 #(
    parameter int TIME_WIDTH = ur3_pkg::TIME_WIDTH_DEF,
    parameter int DIST_WIDTH = ur3_pkg::DIST_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input ticks
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_echo_level,
    // results
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_drive_enable,
    output logic                                o_trigger_level,
    output logic [DIST_WIDTH-1:0]               o_median_distance,
    output logic                                o_sample_accepted,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ur3_pkg::CFG_IDX_WIDTH-1:0]   i_cfg_index,
    input  logic [ur3_pkg::CFG_WIDTH-1:0]       i_cfg_data
);

    ur3_pkg::t_cfg         r_cfg;
    ur3_pkg::t_tmg_status  tmg_status;
    logic [TIME_WIDTH-1:0] duration;
    logic [DIST_WIDTH-1:0] median;
    logic                  accepted;
    logic                  advance;

    logic                  r_valid, n_valid;
    logic                  r_drive, r_level, r_accepted;
    logic [DIST_WIDTH-1:0] r_median;

    assign o_stall     = r_valid && i_stall;
    assign advance     = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_period <= ur3_pkg::TRIGGER_PERIOD_RST;
            r_cfg.echo_timeout   <= ur3_pkg::ECHO_TIMEOUT_RST;
            r_cfg.max_echo_ticks <= ur3_pkg::MAX_ECHO_TICKS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ur3_pkg::REG_TRIGGER_PERIOD: r_cfg.trigger_period <= i_cfg_data;
                ur3_pkg::REG_ECHO_TIMEOUT:   r_cfg.echo_timeout   <= i_cfg_data;
                ur3_pkg::REG_MAX_ECHO_TICKS: r_cfg.max_echo_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ur3_timing #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_timing (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (advance),
        .i_echo     (i_echo_level),
        .i_cfg      (r_cfg),
        .o_status   (tmg_status),
        .o_duration (duration)
    );

    ur3_filter #(
        .TIME_WIDTH (TIME_WIDTH),
        .DIST_WIDTH (DIST_WIDTH)
    ) u_filter (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_advance        (advance),
        .i_fall           (tmg_status.fall),
        .i_duration       (duration),
        .i_max_echo_ticks (r_cfg.max_echo_ticks),
        .o_median         (median),
        .o_accepted       (accepted)
    );

    always_comb begin
        if (advance) begin
            n_valid = 1'b1;
        end else begin
            n_valid = r_valid && i_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_drive    <= tmg_status.drive;
            r_level    <= tmg_status.level;
            r_median   <= median;
            r_accepted <= accepted;
        end
    end

    assign o_valid           = r_valid;
    assign o_drive_enable    = r_drive;
    assign o_trigger_level   = r_level;
    assign o_median_distance = r_median;
    assign o_sample_accepted = r_accepted;

    a_level_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_level) |-> r_drive)
        else $error("trigger level high without drive enable");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_valid)
        else $error("accepted tick produced no result");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_stall) |=>
            (r_valid && $stable({r_drive, r_level, r_median, r_accepted})))
        else $error("stalled result changed");

endmodule

/* rtl/ur3_timing.sv */
// Trigger pulse generator, period counter and echo edge timing.
// Depends on ur3_pkg.
module ur3_timing #(
    parameter int TIME_WIDTH = ur3_pkg::TIME_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_advance,
    input  logic                     i_echo,
    input  ur3_pkg::t_cfg            i_cfg,
    output ur3_pkg::t_tmg_status     o_status,
    output logic [TIME_WIDTH-1:0]    o_duration
);

    localparam int CW = (TIME_WIDTH > ur3_pkg::CFG_WIDTH) ? TIME_WIDTH : ur3_pkg::CFG_WIDTH;
    localparam int PW = ur3_pkg::PHASE_WIDTH;
    localparam logic [PW-1:0] PH_IDLE  = PW'(0);
    localparam logic [PW-1:0] PH_FIRST = PW'(1);
    localparam logic [PW-1:0] PH_LOW   = PW'(ur3_pkg::LOW_TICKS);
    localparam logic [PW-1:0] PH_LAST  = PW'(ur3_pkg::PHASE_LAST);

    logic [TIME_WIDTH-1:0] r_period_count, n_period_count;
    logic [TIME_WIDTH-1:0] r_since_rise,   n_since_rise;
    logic [PW-1:0]         r_phase,        n_phase;
    logic                  r_measuring,    n_measuring;
    logic                  r_listening,    n_listening;
    logic                  r_prev_echo;

    logic                  rise, fall;
    logic                  meas_a, listen_b;
    logic [TIME_WIDTH-1:0] pc_inc;
    logic                  hit, attempt, timed_out, fire, active;
    logic [PW-1:0]         phase_a;

    always_comb begin
        rise = r_listening && i_echo && !r_prev_echo;
        fall = r_listening && !i_echo && r_prev_echo;

        if (rise) begin
            n_since_rise = '0;
        end else if (r_since_rise == '1) begin
            n_since_rise = r_since_rise;
        end else begin
            n_since_rise = r_since_rise + 1'b1;
        end
        meas_a = r_measuring && !fall;

        pc_inc = (r_period_count == '1) ? r_period_count : r_period_count + 1'b1;
        hit    = CW'(pc_inc) >= CW'(i_cfg.trigger_period);
        n_period_count = hit ? '0 : pc_inc;

        // attempt only from idle; a running measurement blocks it until timeout
        attempt   = hit && (r_phase == PH_IDLE);
        timed_out = CW'(n_since_rise) > CW'(i_cfg.echo_timeout);
        fire      = attempt && (!meas_a || timed_out);
        listen_b  = r_listening && !fire;
        phase_a   = fire ? PH_FIRST : r_phase;

        active = (phase_a >= PH_FIRST) && (phase_a <= PH_LAST);
        n_measuring = meas_a && !(attempt && timed_out);
        n_listening = listen_b;
        if (active && phase_a == PH_LAST) begin
            n_phase     = PH_IDLE;
            n_measuring = 1'b1;
            n_listening = 1'b1;
        end else if (active) begin
            n_phase = phase_a + 1'b1;
        end else begin
            n_phase = PH_IDLE;
        end

        o_status.drive = active;
        o_status.level = active && (phase_a > PH_LOW);
        o_status.fall  = fall;
        o_duration     = n_since_rise;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_count <= '0;
            r_since_rise   <= '1;
            r_phase        <= PH_IDLE;
            r_measuring    <= 1'b0;
            r_listening    <= 1'b0;
            r_prev_echo    <= 1'b0;
        end else if (i_advance) begin
            r_period_count <= n_period_count;
            r_since_rise   <= n_since_rise;
            r_phase        <= n_phase;
            r_measuring    <= n_measuring;
            r_listening    <= n_listening;
            r_prev_echo    <= i_echo;
        end
    end

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PH_LAST)
        else $error("trigger phase beyond last high tick");

    a_listen_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_listening && r_phase != PH_IDLE))
        else $error("listening while trigger pulse runs");

    a_meas_listen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_measuring |-> r_listening)
        else $error("measurement running without listening");

endmodule

/* rtl/ur3_filter.sv */
// Echo duration to distance scaling, three-sample store and median select.
// Depends on ur3_pkg.
module ur3_filter #(
    parameter int TIME_WIDTH = ur3_pkg::TIME_WIDTH_DEF,
    parameter int DIST_WIDTH = ur3_pkg::DIST_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_advance,
    input  logic                              i_fall,
    input  logic [TIME_WIDTH-1:0]             i_duration,
    input  logic [ur3_pkg::CFG_WIDTH-1:0]     i_max_echo_ticks,
    output logic [DIST_WIDTH-1:0]             o_median,
    output logic                              o_accepted
);

    localparam int CW = (TIME_WIDTH > ur3_pkg::CFG_WIDTH) ? TIME_WIDTH : ur3_pkg::CFG_WIDTH;
    localparam int MW = TIME_WIDTH + ur3_pkg::SCALE_BITS;
    localparam int QW = MW - ur3_pkg::SCALE_SHIFT;
    localparam int EW = (QW > DIST_WIDTH) ? QW : DIST_WIDTH;
    localparam logic [DIST_WIDTH-1:0] DIST_MAX = '1;
    localparam logic [DIST_WIDTH-1:0] DIST_RST = DIST_WIDTH'(ur3_pkg::DIST_RESET);

    logic [DIST_WIDTH-1:0] r_store [3];
    logic [DIST_WIDTH-1:0] n_store [3];
    logic [1:0]            r_slot, n_slot, slot;

    logic                  in_range;
    logic [MW-1:0]         prod;
    logic [EW-1:0]         q_ext;
    logic [DIST_WIDTH-1:0] scaled_dist;

    function automatic logic [DIST_WIDTH-1:0] med3(
        input logic [DIST_WIDTH-1:0] a,
        input logic [DIST_WIDTH-1:0] b,
        input logic [DIST_WIDTH-1:0] c
    );
        logic [DIST_WIDTH-1:0] lo, hi, m;
        lo = (a < b) ? a : b;
        hi = (a > b) ? a : b;
        m  = (hi < c) ? hi : c;
        return (lo > m) ? lo : m;
    endfunction

    always_comb begin
        in_range = i_fall && (i_duration != '0)
                   && (CW'(i_duration) <= CW'(i_max_echo_ticks));
        prod  = MW'(i_duration) * MW'(ur3_pkg::SCALE_MUL);
        q_ext = EW'(prod[MW-1:ur3_pkg::SCALE_SHIFT]);
        scaled_dist = (q_ext > EW'(DIST_MAX)) ? DIST_MAX : q_ext[DIST_WIDTH-1:0];

        slot = (r_slot > 2'd2) ? 2'd0 : r_slot;
        n_store = r_store;
        n_slot  = r_slot;
        if (in_range) begin
            n_store[slot] = scaled_dist;
            n_slot = (slot == 2'd2) ? 2'd0 : slot + 2'd1;
        end

        // median follows this tick's store update
        o_median   = med3(n_store[0], n_store[1], n_store[2]);
        o_accepted = in_range;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store[0] <= DIST_RST;
            r_store[1] <= DIST_RST;
            r_store[2] <= DIST_RST;
            r_slot     <= 2'd0;
        end else if (i_advance) begin
            r_store <= n_store;
            r_slot  <= n_slot;
        end
    end

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= 2'd2)
        else $error("write slot out of range");

    a_slot_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && o_accepted) |=> (r_slot != $past(r_slot)))
        else $error("accepted sample did not advance write slot");

    a_slot_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && !o_accepted) |=> (r_slot == $past(r_slot)))
        else $error("write slot moved without an accepted sample");

endmodule
